@@ design/stereo_sad_block_match_core_macros.svh @@
// Assertion macros shared by the stereo SAD matcher.
`ifndef STEREO_SAD_BLOCK_MATCH_CORE_MACROS_SVH
`define STEREO_SAD_BLOCK_MATCH_CORE_MACROS_SVH
// implication checked every cycle outside reset
`define SSBM_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("%m: check failed");
// next-cycle implication
`define SSBM_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("%m: check failed");
`endif

@@ design/ssbm_pkg.sv @@
// Types and constants of the stereo SAD block matcher.
package ssbm_pkg;
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = XW + YW;
    localparam int PIX_W = 10;
    localparam int COST_W = 18;
    localparam logic [COST_W-1:0] COST_ABOVE_ALL = '1;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_HX     = 3'd2;
    localparam logic [2:0] REG_HY     = 3'd3;
    localparam logic [2:0] REG_RANGE  = 3'd4;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [8:0] col;
        logic [8:0] row;
        logic [7:0] left_red;
        logic [7:0] left_green;
        logic [7:0] left_blue;
        logic [7:0] right_red;
        logic [7:0] right_green;
        logic [7:0] right_blue;
    } in_word_t;

    typedef struct packed {
        logic [8:0] out_col;
        logic [8:0] out_row;
        logic [6:0] disparity;
    } out_word_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // write pixel pair from held word
        logic q_init;      // latch query, clear best
        logic off_init;    // clear window cost, start window walk
        logic pix_issue;   // issue frame read, advance window counters
        logic off_done;    // compare and step offset
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic no_offsets;  // search range is zero
        logic win_last;    // current read is the last of the window
        logic off_last;    // current offset is the last one
        logic acc_idle;    // read pipeline drained
    } dp_stat_t;
endpackage

@@ design/ssbm_datapath.sv @@
// Datapath: frame stores, window address walk, SAD accumulate and best search.
`include "stereo_sad_block_match_core_macros.svh"
module ssbm_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ssbm_pkg::in_word_t       in_word,
    input  logic                     cfg_we,
    input  logic [2:0]               cfg_index,
    input  logic [9:0]               cfg_data,
    input  ssbm_pkg::dp_cmd_t        cmd,
    output ssbm_pkg::dp_stat_t       stat,
    output ssbm_pkg::out_word_t      res
);
    logic [ssbm_pkg::PIX_W-1:0] left_mem  [0:ssbm_pkg::MAX_WIDTH*ssbm_pkg::MAX_HEIGHT-1];
    logic [ssbm_pkg::PIX_W-1:0] right_mem [0:ssbm_pkg::MAX_WIDTH*ssbm_pkg::MAX_HEIGHT-1];

    logic [9:0] width_reg, height_reg;
    logic [2:0] hx_reg, hy_reg;
    logic [6:0] range_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            width_reg  <= 10'd512;
            height_reg <= 10'd512;
            hx_reg     <= 3'd5;
            hy_reg     <= 3'd5;
            range_reg  <= 7'd80;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ssbm_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                ssbm_pkg::REG_HEIGHT: height_reg <= cfg_data;
                ssbm_pkg::REG_HX:     hx_reg     <= cfg_data[2:0];
                ssbm_pkg::REG_HY:     hy_reg     <= cfg_data[2:0];
                ssbm_pkg::REG_RANGE:  range_reg  <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // effective clamp edges
    logic signed [11:0] xmax, ymax;
    always_comb begin
        if (width_reg == 10'd0) xmax = 12'sd0;
        else if (width_reg > 10'(ssbm_pkg::MAX_WIDTH)) xmax = 12'(ssbm_pkg::MAX_WIDTH - 1);
        else xmax = $signed({2'b00, width_reg}) - 12'sd1;
        if (height_reg == 10'd0) ymax = 12'sd0;
        else if (height_reg > 10'(ssbm_pkg::MAX_HEIGHT)) ymax = 12'(ssbm_pkg::MAX_HEIGHT - 1);
        else ymax = $signed({2'b00, height_reg}) - 12'sd1;
    end

    // query context
    logic [8:0] qcol_reg, qrow_reg;
    logic signed [7:0] k_reg;          // current offset
    logic signed [3:0] i_reg, j_reg;   // window walk
    logic [ssbm_pkg::COST_W-1:0] cost_reg, best_cost_reg;
    logic [6:0] best_off_reg;

    logic signed [7:0] neg_r;
    assign neg_r = -$signed({1'b0, range_reg});

    logic signed [3:0] hxs, hys;
    assign hxs = $signed({1'b0, hx_reg});
    assign hys = $signed({1'b0, hy_reg});

    assign stat.no_offsets = (range_reg == 7'd0);
    assign stat.win_last   = (i_reg == hxs) && (j_reg == hys);
    assign stat.off_last   = (k_reg == $signed({1'b0, range_reg}) - 8'sd1);

    function automatic logic [11:0] clampc(input logic signed [11:0] v,
                                          input logic signed [11:0] hi);
        if (v < 0) return 12'd0;
        if (v > hi) return hi;
        return v;
    endfunction

    logic signed [11:0] xl_s, xr_s, y_s;
    logic [11:0] xl_c, xr_c, y_c;
    always_comb begin
        xl_s = $signed({3'b000, qcol_reg}) + 12'(i_reg);
        xr_s = $signed({3'b000, qcol_reg}) - 12'(k_reg) + 12'(i_reg);
        y_s  = $signed({3'b000, qrow_reg}) + 12'(j_reg);
        xl_c = clampc(xl_s, xmax);
        xr_c = clampc(xr_s, xmax);
        y_c  = clampc(y_s, ymax);
    end

    logic [ssbm_pkg::AW-1:0] rd_l_addr, rd_r_addr, wr_addr;
    assign rd_l_addr = {y_c[ssbm_pkg::YW-1:0], xl_c[ssbm_pkg::XW-1:0]};
    assign rd_r_addr = {y_c[ssbm_pkg::YW-1:0], xr_c[ssbm_pkg::XW-1:0]};
    assign wr_addr = {in_word.row, in_word.col};

    logic [ssbm_pkg::PIX_W-1:0] l_q_reg, r_q_reg;
    always_ff @(posedge clk) begin
        if (cmd.load) begin
            left_mem[wr_addr]  <= 10'(in_word.left_red) + 10'(in_word.left_green)
                                + 10'(in_word.left_blue);
            right_mem[wr_addr] <= 10'(in_word.right_red) + 10'(in_word.right_green)
                                + 10'(in_word.right_blue);
        end
        l_q_reg <= left_mem[rd_l_addr];
        r_q_reg <= right_mem[rd_r_addr];
    end

    // read data is valid in the cycle after issue
    logic rd_vld_reg;
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) rd_vld_reg <= 1'b0;
        else rd_vld_reg <= cmd.pix_issue;
    end
    assign stat.acc_idle = !rd_vld_reg;

    logic [ssbm_pkg::PIX_W-1:0] diff;
    assign diff = (l_q_reg > r_q_reg) ? l_q_reg - r_q_reg : r_q_reg - l_q_reg;

    logic [6:0] k_abs;
    assign k_abs = k_reg[7] ? 7'(-k_reg) : k_reg[6:0];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            qcol_reg <= '0; qrow_reg <= '0; k_reg <= '0;
            i_reg <= '0; j_reg <= '0;
            cost_reg <= '0; best_cost_reg <= ssbm_pkg::COST_ABOVE_ALL; best_off_reg <= '0;
        end else begin
            if (cmd.q_init) begin
                qcol_reg <= in_word.col;
                qrow_reg <= in_word.row;
                k_reg <= neg_r;
                best_cost_reg <= ssbm_pkg::COST_ABOVE_ALL;
                best_off_reg <= '0;
            end
            if (cmd.off_init) begin
                cost_reg <= '0;
                i_reg <= -hxs;
                j_reg <= -hys;
            end else if (rd_vld_reg) begin
                cost_reg <= cost_reg + 18'(diff);
            end
            if (cmd.pix_issue) begin
                if (j_reg == hys) begin
                    j_reg <= -hys;
                    i_reg <= i_reg + 4'sd1;
                end else begin
                    j_reg <= j_reg + 4'sd1;
                end
            end
            if (cmd.off_done) begin
                if (cost_reg < best_cost_reg) begin
                    best_cost_reg <= cost_reg;
                    best_off_reg <= k_abs;
                end
                k_reg <= k_reg + 8'sd1;
            end
        end
    end

    assign res.out_col = qcol_reg;
    assign res.out_row = qrow_reg;
    assign res.disparity = best_off_reg;

    `SSBM_ASSERT_NEXT(a_issue_valid, clk, rst_n, cmd.pix_issue, rd_vld_reg)
    `SSBM_ASSERT_IMP(a_no_cmp_midread, clk, rst_n, cmd.off_done, !rd_vld_reg)
    `SSBM_ASSERT_NEXT(a_query_clears_best, clk, rst_n, cmd.q_init,
        best_cost_reg == ssbm_pkg::COST_ABOVE_ALL && best_off_reg == 7'd0)
endmodule

@@ design/ssbm_ctrl.sv @@
// Controller: sequences loads and the offset by window SAD search of a query.
`include "stereo_sad_block_match_core_macros.svh"
module ssbm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                kind,
    input  ssbm_pkg::dp_stat_t  stat,
    output ssbm_pkg::dp_cmd_t   cmd,
    output logic                busy,
    output logic                done
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_OINIT = 3'd1;
    localparam logic [2:0] S_PIX   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic accept;
    assign accept = start && (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    if (kind == ssbm_pkg::KIND_LOAD) begin
                        cmd.load = 1'b1;
                    end else begin
                        cmd.q_init = 1'b1;
                        state_next = stat.no_offsets ? S_DONE : S_OINIT;
                    end
                end
            end
            S_OINIT: begin
                cmd.off_init = 1'b1;
                state_next = S_PIX;
            end
            S_PIX: begin
                cmd.pix_issue = 1'b1;
                if (stat.win_last) state_next = S_DRAIN;
            end
            S_DRAIN: state_next = S_CMP;
            S_CMP: begin
                cmd.off_done = 1'b1;
                state_next = stat.off_last ? S_DONE : S_OINIT;
            end
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    `SSBM_ASSERT_NEXT(a_query_busy, clk, rst_n, accept && kind == ssbm_pkg::KIND_QUERY, busy)
    `SSBM_ASSERT_IMP(a_cmp_drained, clk, rst_n, state_reg == S_CMP, stat.acc_idle)
    `SSBM_ASSERT_NEXT(a_done_once, clk, rst_n, done, !done)
endmodule

@@ design/stereo_sad_block_match_core.sv @@
// Stereo SAD block matcher, top level.
// Usage:
//  - start/busy command channel: a word is taken at an edge with start high and
//    busy low. Kind load writes the left/right grey pixel pair (channel sums)
//    as the word is taken and gives no result; busy stays low.
//  - Kind query searches offsets -search_range..search_range-1 with a
//    (2hx+1)x(2hy+1) window SAD, clamped at the image edges.
//  - Result: done pulses one cycle with col, row and disparity on result.
//  - One pixel pair is read per cycle from the single-read frame stores;
//    that port sets the rate. Per offset, setup, the read latency and the
//    compare add to the window reads.
//  - Config writes (cfg_we, cfg_index, cfg_data) take effect at once; write
//    only while busy is low.
//  - Reset restores register defaults and idles the controller; frame
//    contents are undefined until loaded.
//  - The receiver cannot stall: the result word is valid only while done.
module stereo_sad_block_match_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ssbm_pkg::in_word_t   cmd_word,
    output logic                 done,
    output ssbm_pkg::out_word_t  result,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [9:0]           cfg_data
);
    ssbm_pkg::dp_cmd_t  cmd;
    ssbm_pkg::dp_stat_t stat;

    ssbm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .kind(cmd_word.kind),
        .stat(stat), .cmd(cmd), .busy(busy), .done(done)
    );

    ssbm_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .in_word(cmd_word), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .stat(stat),
        .res(result)
    );
endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the stereo SAD block matcher.
`timescale 1ns / 1ps

class sad_scoreboard;
    bit [9:0] left_grey[ssbm_pkg::MAX_WIDTH * ssbm_pkg::MAX_HEIGHT];
    bit [9:0] right_grey[ssbm_pkg::MAX_WIDTH * ssbm_pkg::MAX_HEIGHT];
    int unsigned img_w, img_h, half_x, half_y, range_r;
    ssbm_pkg::out_word_t disparity_q[$];
    int unsigned errors;

    function new();
        img_w = 512;
        img_h = 512;
        half_x = 5;
        half_y = 5;
        range_r = 80;
        errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [9:0] val);
        case (idx)
            ssbm_pkg::REG_WIDTH:  img_w = 32'(val);
            ssbm_pkg::REG_HEIGHT: img_h = 32'(val);
            ssbm_pkg::REG_HX:     half_x = 32'(val[2:0]);
            ssbm_pkg::REG_HY:     half_y = 32'(val[2:0]);
            ssbm_pkg::REG_RANGE:  range_r = 32'(val[6:0]);
            default: ;
        endcase
    endfunction

    function automatic int clamp(int v, int hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    function void note_word(ssbm_pkg::in_word_t w);
        int xmax, ymax, k, i, j, xl, xr, y, a, b;
        int unsigned cost, best_cost, best_k;
        ssbm_pkg::out_word_t exp_word;
        if (w.kind == ssbm_pkg::KIND_LOAD) begin
            left_grey[w.row * ssbm_pkg::MAX_WIDTH + w.col] =
                10'(w.left_red) + 10'(w.left_green) + 10'(w.left_blue);
            right_grey[w.row * ssbm_pkg::MAX_WIDTH + w.col] =
                10'(w.right_red) + 10'(w.right_green) + 10'(w.right_blue);
            return;
        end
        xmax = (img_w == 0) ? 0 : ((img_w > ssbm_pkg::MAX_WIDTH) ?
               ssbm_pkg::MAX_WIDTH - 1 : int'(img_w) - 1);
        ymax = (img_h == 0) ? 0 : ((img_h > ssbm_pkg::MAX_HEIGHT) ?
               ssbm_pkg::MAX_HEIGHT - 1 : int'(img_h) - 1);
        best_cost = 32'h3FFFF;
        best_k = 0;
        for (k = -int'(range_r); k < int'(range_r); k++) begin
            cost = 0;
            for (i = -int'(half_x); i <= int'(half_x); i++) begin
                xl = clamp(int'(w.col) + i, xmax);
                xr = clamp(int'(w.col) - k + i, xmax);
                for (j = -int'(half_y); j <= int'(half_y); j++) begin
                    y = clamp(int'(w.row) + j, ymax);
                    a = int'(left_grey[y * ssbm_pkg::MAX_WIDTH + xl]);
                    b = int'(right_grey[y * ssbm_pkg::MAX_WIDTH + xr]);
                    cost += (a > b) ? (a - b) : (b - a);
                end
            end
            cost &= 32'h3FFFF;
            if (cost < best_cost) begin
                best_cost = cost;
                best_k = (k < 0) ? -k : k;
            end
        end
        exp_word.out_col = w.col;
        exp_word.out_row = w.row;
        exp_word.disparity = best_k[6:0];
        disparity_q.push_back(exp_word);
    endfunction

    function void check(ssbm_pkg::out_word_t got);
        ssbm_pkg::out_word_t exp_word;
        if (disparity_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result word col=%0d row=%0d disp=%0d",
                         got.out_col, got.out_row, got.disparity);
            return;
        end
        exp_word = disparity_q.pop_front();
        if (got.out_col !== exp_word.out_col || got.out_row !== exp_word.out_row
            || got.disparity !== exp_word.disparity) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: exp col=%0d row=%0d disp=%0d, got col=%0d row=%0d disp=%0d",
                         exp_word.out_col, exp_word.out_row, exp_word.disparity,
                         got.out_col, got.out_row, got.disparity);
        end
    endfunction
endclass

module tb_top;
    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    ssbm_pkg::in_word_t   cmd_word;
    logic                 done;
    ssbm_pkg::out_word_t  result;
    logic                 cfg_we;
    logic [2:0]           cfg_index;
    logic [9:0]           cfg_data;

    sad_scoreboard sb;
    int unsigned idle_pct;
    int unsigned pat_seed;

    stereo_sad_block_match_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd_word  (cmd_word),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
        if (rst_n && done)
            sb.check(result);

    task automatic send_word(ssbm_pkg::in_word_t w);
        int unsigned gap;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd_word <= w;
        do @(posedge clk); while (busy);
        sb.note_word(w);
    endtask

    // stop sending and let every pending query come back
    task automatic drain();
        start <= 1'b0;
        while (sb.disparity_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [9:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic configure(int w, int h, int hx, int hy, int r);
        write_reg(ssbm_pkg::REG_WIDTH, 10'(w));
        write_reg(ssbm_pkg::REG_HEIGHT, 10'(h));
        write_reg(ssbm_pkg::REG_HX, 10'(hx));
        write_reg(ssbm_pkg::REG_HY, 10'(hy));
        write_reg(ssbm_pkg::REG_RANGE, 10'(r));
    endtask

    function automatic logic [7:0] texel(int c, int r, int ch);
        logic [31:0] hv;
        hv = (c * 37 + r * 101 + ch * 7919 + pat_seed) * 32'h9E3779B1;
        return hv[31:24];
    endfunction

    // right frame is the left pattern shifted by shift columns, with some noise
    function automatic ssbm_pkg::in_word_t pixel_word(int c, int r, int shift);
        ssbm_pkg::in_word_t w;
        w.kind = ssbm_pkg::KIND_LOAD;
        w.col = 9'(c);
        w.row = 9'(r);
        w.left_red = texel(c, r, 0);
        w.left_green = texel(c, r, 1);
        w.left_blue = texel(c, r, 2);
        w.right_red = texel(c + shift, r, 0);
        w.right_green = texel(c + shift, r, 1);
        w.right_blue = texel(c + shift, r, 2);
        if ($urandom_range(9) == 0)
            w.right_blue = 8'($urandom_range(255));
        return w;
    endfunction

    task automatic fill_frame(int w, int h, int shift);
        int c, r;
        for (r = 0; r < h; r++)
            for (c = 0; c < w; c++)
                send_word(pixel_word(c, r, shift));
    endtask

    task automatic query(int c, int r);
        ssbm_pkg::in_word_t w;
        w = '0;
        w.kind = ssbm_pkg::KIND_QUERY;
        w.col = 9'(c);
        w.row = 9'(r);
        w.left_red = 8'($urandom_range(255));
        w.right_blue = 8'($urandom_range(255));
        send_word(w);
    endtask

    initial begin
        #(100_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int ph, n, w, h, shift, c;
        ssbm_pkg::in_word_t lw;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd_word = '0;
        cfg_we = 1'b0;
        cfg_index = ssbm_pkg::REG_WIDTH;
        cfg_data = '0;
        sb = new();
        idle_pct = 0;
        pat_seed = $urandom;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: small image, channel extremes, corners, outside queries
        configure(5, 3, 1, 1, 4);
        lw = '0;
        send_word(lw);
        lw = '1;
        lw.kind = ssbm_pkg::KIND_LOAD;
        lw.col = 9'd1;
        lw.row = 9'd0;
        send_word(lw);
        fill_frame(5, 3, 2);
        lw = '1;
        lw.kind = ssbm_pkg::KIND_LOAD;
        send_word(lw);            // beyond the image but inside the store
        query(0, 0);
        query(4, 2);
        query(2, 1);
        query(511, 511);
        query(3, 300);
        drain();

        // zero sizes act as 1x1, widest window
        configure(0, 0, 7, 7, 1);
        send_word(pixel_word(0, 0, 0));
        query(0, 0);
        query(511, 0);
        query(0, 511);
        drain();

        // oversized width, one row: only the columns near both ends are read
        configure(1023, 1, 0, 0, 3);
        for (c = 0; c < 8; c++)
            send_word(pixel_word(c, 0, 5));
        for (c = 504; c < 512; c++)
            send_word(pixel_word(c, 0, 5));
        query(0, 0);
        query(511, 0);
        query(3, 0);
        drain();

        // widest window and full search range on a tiny image
        configure(4, 2, 7, 7, 127);
        fill_frame(4, 2, 3);
        query(1, 1);
        query(3, 0);
        drain();

        // no offsets searched
        configure(2, 2, 2, 3, 0);
        fill_frame(2, 2, 1);
        query(1, 1);
        query(400, 100);
        drain();

        // random phases with shifting sender pressure
        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: idle_pct = 0;
                1: idle_pct = 57;
                default: idle_pct = 21;
            endcase
            pat_seed = $urandom;
            w = $urandom_range(1, 4);
            h = $urandom_range(1, 3);
            shift = $urandom_range(0, 3);
            configure(w, h, $urandom_range(0, 3), $urandom_range(0, 3),
                      $urandom_range(1, 20));
            fill_frame(w, h, shift);
            for (n = 0; n < 8; n++) begin
                if ($urandom_range(2) == 0) begin
                    // reload inside the image, or anywhere in the store
                    if ($urandom_range(3) == 0) begin
                        lw = '0;
                        lw.kind = ssbm_pkg::KIND_LOAD;
                        lw.col = 9'($urandom_range(511));
                        lw.row = 9'($urandom_range(511));
                        lw.left_red = 8'($urandom_range(255));
                        lw.left_green = 8'($urandom_range(255));
                        lw.left_blue = 8'($urandom_range(255));
                        lw.right_red = 8'($urandom_range(255));
                        lw.right_green = 8'($urandom_range(255));
                        lw.right_blue = 8'($urandom_range(255));
                        send_word(lw);
                    end else begin
                        send_word(pixel_word($urandom_range(w - 1), $urandom_range(h - 1),
                                             shift));
                    end
                end else if ($urandom_range(4) == 0) begin
                    query($urandom_range(511), $urandom_range(511));
                end else begin
                    query($urandom_range(w - 1), $urandom_range(h - 1));
                end
            end
            drain();
        end

        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.disparity_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
